### src/irptt_pkg.sv
// irptt_pkg: shared types and constants for the ir pulse train transmitter
// used by irptt_core and ir_pulse_train_transmitter; no dependencies
package irptt_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] REG_CARRIER_ON  = 2'd0;
  localparam logic [1:0] REG_CARRIER_OFF = 2'd1;
  localparam logic [1:0] REG_UNIT        = 2'd2;
  localparam logic [1:0] REG_SEQ_LEN     = 2'd3;

  localparam logic [7:0] CARRIER_ON_RST  = 8'd8;
  localparam logic [7:0] CARRIER_OFF_RST = 8'd7;
  localparam logic [7:0] UNIT_RST        = 8'd10;
  localparam logic [7:0] SEQ_LEN_RST     = 8'd75;

  localparam int ELAPSED_W = 24;
  localparam int PHASE_W   = 9;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [7:0] carrier_on_ticks;
    logic [7:0] carrier_off_ticks;
    logic [7:0] unit_ticks;
    logic [7:0] sequence_length;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic finished;
  } result_t;

endpackage

### src/irptt_core.sv
// irptt_core: duration table memory and playback state (pointer, elapsed, carrier phase)
// depends on irptt_pkg; the result is combinational for the beat being accepted
module irptt_core import irptt_pkg::*; #(
  parameter int TABLE_DEPTH    = 128,
  parameter int DURATION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  cmd,
  input  logic [6:0]  entry_index,
  input  logic [15:0] entry_value,
  input  cfg_t        cfg,
  output result_t     res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = DURATION_WIDTH + 8;

  logic [DURATION_WIDTH-1:0] dur_mem [TABLE_DEPTH];
  logic [DURATION_WIDTH-1:0] rdata;
  logic [DURATION_WIDTH-1:0] wdata;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic                      wr_en;

  logic [AW-1:0]        ptr, ptr_next;
  logic [AW:0]          ptr_inc;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [PHASE_W-1:0]   phase, phase_next, phase_inc, period_sum, period;
  logic                 playing, playing_next;
  logic [PW-1:0]        entry_len;
  logic [LW-1:0]        seq_len;
  logic                 period_end, entry_end, last_entry;
  logic                 level, done;

  always_comb begin
    wr_en = accept && (cmd == CMD_WRITE) && (32'(entry_index) < TABLE_DEPTH);
    waddr = AW'(entry_index);
    wdata = DURATION_WIDTH'(entry_value);

    period_sum = PHASE_W'(cfg.carrier_on_ticks) + PHASE_W'(cfg.carrier_off_ticks);
    period     = (period_sum == '0) ? PHASE_W'(1) : period_sum;
    phase_inc  = phase + 1'b1;
    period_end = phase_inc >= period;

    elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
    entry_len   = PW'(rdata) * PW'(cfg.unit_ticks);
    entry_end   = elapsed_inc >= ELAPSED_W'(entry_len);

    if (cfg.sequence_length == 8'd0) begin
      seq_len = LW'(1);
    end else if (32'(cfg.sequence_length) > TABLE_DEPTH) begin
      seq_len = LW'(TABLE_DEPTH);
    end else begin
      seq_len = LW'(cfg.sequence_length);
    end
    ptr_inc    = {1'b0, ptr} + 1'b1;
    last_entry = 32'(ptr_inc) >= 32'(seq_len);
  end

  always_comb begin
    ptr_next     = ptr;
    elapsed_next = elapsed;
    phase_next   = phase;
    playing_next = playing;
    level        = 1'b0;
    done         = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_START: begin
          ptr_next     = '0;
          elapsed_next = '0;
          phase_next   = '0;
          playing_next = 1'b1;
        end
        CMD_TICK: begin
          if (playing) begin
            level        = !ptr[0] && (PHASE_W'(cfg.carrier_on_ticks) > phase);
            elapsed_next = elapsed_inc;
            phase_next   = phase_inc;
            if (period_end) begin
              phase_next = '0;
              if (entry_end) begin
                elapsed_next = '0;
                if (last_entry) begin
                  ptr_next     = '0;
                  playing_next = 1'b0;
                  done         = 1'b1;
                end else begin
                  ptr_next = AW'(ptr_inc);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    raddr = ptr_next;
    res   = '{ir_level: level, busy_res: playing_next, finished: done};
  end

  // read the entry that the pointer will hold next, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dur_mem[waddr] <= wdata;
    end
    if (wr_en && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= dur_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      elapsed <= '0;
      phase   <= '0;
      playing <= 1'b0;
    end else begin
      ptr     <= ptr_next;
      elapsed <= elapsed_next;
      phase   <= phase_next;
      playing <= playing_next;
    end
  end

  a_done_ends_play: assert property (@(posedge clk) disable iff (rst)
    accept && res.finished |=> !playing && (ptr == '0))
    else $error("finish did not leave the block idle at entry zero");

  a_idle_ptr_zero: assert property (@(posedge clk) disable iff (rst)
    !playing |-> (ptr == '0) && (elapsed == '0))
    else $error("pointer or elapsed count moved while idle");

  a_mark_only: assert property (@(posedge clk) disable iff (rst)
    accept && res.ir_level |-> playing && !ptr[0] && (cmd == CMD_TICK))
    else $error("carrier driven outside a mark");

  a_start_fresh: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_START) |=> playing && (phase == '0) && (elapsed == '0))
    else $error("start did not open a fresh carrier period");

endmodule

### src/ir_pulse_train_transmitter.sv
// ir_pulse_train_transmitter: top level with handshakes, config registers and result register
// depends on irptt_pkg and irptt_core
//
// Takes one beat every cycle while results are taken; each beat is a tick, a table write or
// a start, and gives one result beat in the cycle after it is taken. The result sits in an
// output register: a new beat is taken in the cycle the waiting result leaves, and the input
// stalls for as long as the result waits. The duration of the entry the pointer is about to
// hold is read from the table memory at the same edge that moves the pointer, so an entry
// change adds no delay; a write to that entry in the same beat is forwarded. Config
// writes take effect on the next beat.
module ir_pulse_train_transmitter import irptt_pkg::*; #(
  parameter int TABLE_DEPTH    = 128,
  parameter int DURATION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [6:0]  entry_index,
  input  logic [15:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ir_level,
  output logic        busy_res,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_on_ticks  <= CARRIER_ON_RST;
      cfg.carrier_off_ticks <= CARRIER_OFF_RST;
      cfg.unit_ticks        <= UNIT_RST;
      cfg.sequence_length   <= SEQ_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CARRIER_ON:  cfg.carrier_on_ticks  <= cfg_data;
        REG_CARRIER_OFF: cfg.carrier_off_ticks <= cfg_data;
        REG_UNIT:        cfg.unit_ticks        <= cfg_data;
        REG_SEQ_LEN:     cfg.sequence_length   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  irptt_core #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .DURATION_WIDTH (DURATION_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_level <= res.ir_level;
      busy_res <= res.busy_res;
      finished <= res.finished;
    end
  end

endmodule
